>>> rtl/tldw_pkg.sv
// Shared types, constants and the segment lookup for the two-wire LED display writer.
// No dependencies; every other file of the block imports this package.
package tldw_pkg;

   // Default depth of the command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Configuration port geometry and register indexes.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BRIGHTNESS = 1'b0;
   localparam logic REG_COLON      = 1'b1;

   // Protocol bytes.
   localparam logic [7:0] DATA_MODE_BYTE = 8'h40;
   localparam logic [7:0] ADDR_BYTE      = 8'hC0;
   localparam logic [7:0] BRIGHT_BASE    = 8'h87;
   localparam logic [3:0] BRIGHT_MAX     = 4'd8;
   localparam logic [7:0] COLON_BIT      = 8'h80;

   // Divide by ten as a multiply by a scaled reciprocal, exact for 16-bit values.
   localparam logic [16:0] RECIP_TEN = 17'h0CCCD;

   typedef enum logic [1:0] {
      SYM_START = 2'd0,
      SYM_DATA  = 2'd1,
      SYM_ACK   = 2'd2,
      SYM_STOP  = 2'd3
   } sym_kind_type;

   // One classified command. For a brightness command seg[0] holds the byte to send.
   typedef struct packed {
      logic            bright;
      logic [3:0][7:0] seg;
   } entry_type;

   function automatic logic [7:0] seg_of_digit(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   typedef enum logic [1:0] {
      F_IDLE = 2'd0,
      F_CONV = 2'd1,
      F_PUSH = 2'd2
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE  = 2'd0,
      B_START = 2'd1,
      B_BITS  = 2'd2,
      B_STOP  = 2'd3
   } back_state_type;

endpackage

>>> rtl/tldw_front.sv
// Front end: accepts commands, converts numbers to segment bytes one digit per cycle.
// Depends on tldw_pkg; feeds tldw_queue.
module tldw_front import tldw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_number,
   input  logic [3:0]  brightness_level,
   input  logic        colon_on,
   input  logic        q_full,
   output logic        q_push,
   output entry_type   q_wdata
);

   front_state_type fstate_ff, fstate_in;
   logic [15:0]     val_ff, val_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [3:0][7:0] seg_ff, seg_in;
   logic            bright_ff, bright_in;

   logic            take;
   logic [32:0]     prod;
   logic [13:0]     quot;
   logic [15:0]     quot_x10;
   logic [3:0]      digit;
   logic [7:0]      digit_seg;
   logic [3:0]      lvl;
   logic [7:0]      bright_byte;

   always_comb begin
      // Quotient and remainder of the working value by ten.
      prod      = 33'(val_ff) * 33'(RECIP_TEN);
      quot      = prod[32:19];
      quot_x10  = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
      digit     = 4'(val_ff - quot_x10);
      digit_seg = seg_of_digit(digit);
      // The hundreds digit carries the colon.
      if (colon_on && (cnt_ff == 2'd2)) begin
         digit_seg = digit_seg | COLON_BIT;
      end

      lvl         = (brightness_level > BRIGHT_MAX) ? BRIGHT_MAX : brightness_level;
      bright_byte = BRIGHT_BASE + {4'b0000, lvl};

      fstate_in = fstate_ff;
      val_in    = val_ff;
      cnt_in    = cnt_ff;
      seg_in    = seg_ff;
      bright_in = bright_ff;
      req_ready = 1'b0;
      q_push    = 1'b0;
      take      = 1'b0;

      case (fstate_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            take      = req_valid;
         end
         F_CONV: begin
            seg_in[cnt_ff] = digit_seg;
            val_in         = 16'(quot);
            cnt_in         = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               fstate_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push    = 1'b1;
               req_ready = 1'b1;
               take      = req_valid;
               fstate_in = F_IDLE;
            end
         end
         default: begin
            fstate_in = F_IDLE;
         end
      endcase

      if (take) begin
         if (req_cmd) begin
            bright_in = 1'b1;
            seg_in[0] = bright_byte;
            fstate_in = F_PUSH;
         end else begin
            bright_in = 1'b0;
            val_in    = req_number;
            cnt_in    = 2'd0;
            fstate_in = F_CONV;
         end
      end
   end

   assign q_wdata.bright = bright_ff;
   assign q_wdata.seg    = seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff <= F_IDLE;
      end else begin
         fstate_ff <= fstate_in;
      end
      val_ff    <= val_in;
      cnt_ff    <= cnt_in;
      seg_ff    <= seg_in;
      bright_ff <= bright_in;
   end

endmodule

>>> rtl/tldw_queue.sv
// Short register queue of classified commands between the front and the back.
// Depends on tldw_pkg for the entry type.
module tldw_queue import tldw_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wdata,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type         mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/tldw_back.sv
// Back end: walks a queued command frame by frame; one line symbol per cycle unless stalled.
// Depends on tldw_pkg; reads from tldw_queue and drives the result register.
module tldw_back import tldw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_symbol_kind,
   output logic       rsp_bit_value,
   output logic       rsp_last_symbol
);

   back_state_type bstate_ff, bstate_in;
   entry_type      cur_ff, cur_in;
   logic           frame_ff, frame_in;
   logic [2:0]     byte_ff, byte_in;
   logic [3:0]     bit_ff, bit_in;

   logic           valid_ff, valid_in;
   sym_kind_type   kind_ff, kind_in;
   logic           value_ff, value_in;
   logic           last_ff, last_in;

   logic           adv;
   logic           last_byte;
   logic [7:0]     cur_byte;
   logic [1:0]     seg_idx;

   always_comb begin
      adv       = !valid_ff || rsp_ready;
      seg_idx   = 2'(3'd4 - byte_ff);
      last_byte = cur_ff.bright || !frame_ff || (byte_ff == 3'd4);

      if (cur_ff.bright) begin
         cur_byte = cur_ff.seg[0];
      end else if (!frame_ff) begin
         cur_byte = DATA_MODE_BYTE;
      end else if (byte_ff == 3'd0) begin
         cur_byte = ADDR_BYTE;
      end else begin
         cur_byte = cur_ff.seg[seg_idx];
      end

      bstate_in = bstate_ff;
      cur_in    = cur_ff;
      frame_in  = frame_ff;
      byte_in   = byte_ff;
      bit_in    = bit_ff;
      pop       = 1'b0;
      valid_in  = valid_ff && !rsp_ready;
      kind_in   = kind_ff;
      value_in  = value_ff;
      last_in   = last_ff;

      if (adv) begin
         case (bstate_ff)
            B_IDLE: begin
               if (head_valid) begin
                  pop       = 1'b1;
                  cur_in    = head;
                  frame_in  = 1'b0;
                  byte_in   = 3'd0;
                  bit_in    = 4'd0;
                  valid_in  = 1'b1;
                  kind_in   = SYM_START;
                  value_in  = 1'b0;
                  last_in   = 1'b0;
                  bstate_in = B_BITS;
               end
            end
            B_START: begin
               byte_in   = 3'd0;
               bit_in    = 4'd0;
               valid_in  = 1'b1;
               kind_in   = SYM_START;
               value_in  = 1'b0;
               last_in   = 1'b0;
               bstate_in = B_BITS;
            end
            B_BITS: begin
               valid_in = 1'b1;
               last_in  = 1'b0;
               if (bit_ff == 4'd8) begin
                  kind_in  = SYM_ACK;
                  value_in = 1'b0;
                  bit_in   = 4'd0;
                  if (last_byte) begin
                     bstate_in = B_STOP;
                  end else begin
                     byte_in = byte_ff + 3'd1;
                  end
               end else begin
                  kind_in  = SYM_DATA;
                  value_in = cur_byte[bit_ff[2:0]];
                  bit_in   = bit_ff + 4'd1;
               end
            end
            B_STOP: begin
               valid_in = 1'b1;
               kind_in  = SYM_STOP;
               value_in = 1'b0;
               last_in  = cur_ff.bright || frame_ff;
               if (cur_ff.bright || frame_ff) begin
                  bstate_in = B_IDLE;
               end else begin
                  frame_in  = 1'b1;
                  bstate_in = B_START;
               end
            end
            default: begin
               bstate_in = B_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_symbol_kind = kind_ff;
   assign rsp_bit_value   = value_ff;
   assign rsp_last_symbol = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff <= B_IDLE;
         valid_ff  <= 1'b0;
      end else begin
         bstate_ff <= bstate_in;
         valid_ff  <= valid_in;
      end
      cur_ff   <= cur_in;
      frame_ff <= frame_in;
      byte_ff  <= byte_in;
      bit_ff   <= bit_in;
      kind_ff  <= kind_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

endmodule

>>> rtl/two_wire_led_display_writer.sv
// Top level of the two-wire LED display writer: configuration registers and the
// front, queue and back parts. Depends on tldw_pkg, tldw_front, tldw_queue, tldw_back.
//
//   Channel   Direction  Handshake           Carries
//   req_      in         req_valid/ready     cmd, number
//   rsp_      out        rsp_valid/ready     symbol_kind, bit_value, last_symbol
//   csr (APB) in/out     psel/penable/pready brightness_level (0x0), colon_on (0x4)
//
// The back part emits one line symbol per cycle while rsp_ready does not stall it: a
// show-number command is sent as a data-mode frame, then an address frame with four
// segment bytes; a brightness command as one frame. The front converts a number one
// digit per cycle through a divide-by-ten multiplier, overlapped with the back's work.
// Reset sets brightness to 2, clears the colon and empties the queue.
// A stalled result waits in the output register while the front keeps accepting
// items until the queue fills.
module two_wire_led_display_writer import tldw_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Command channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [15:0]           req_number,
   // Line symbol channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_symbol_kind,
   output logic                  rsp_bit_value,
   output logic                  rsp_last_symbol,
   // Configuration port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [3:0] bright_ff, bright_in;
   logic       colon_ff, colon_in;
   logic       csr_wr;
   logic       reg_idx;

   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_head_valid;
   entry_type  q_wdata;
   entry_type  q_head;

   // Registers sit at 4-byte spacing, so bit 2 of the address picks one.
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign reg_idx = paddr[2];

   always_comb begin
      bright_in = bright_ff;
      colon_in  = colon_ff;
      prdata    = '0;
      case (reg_idx)
         REG_BRIGHTNESS: begin
            prdata = CSR_DATA_W'(bright_ff);
            if (csr_wr) begin
               bright_in = pwdata[3:0];
            end
         end
         REG_COLON: begin
            prdata = CSR_DATA_W'(colon_ff);
            if (csr_wr) begin
               colon_in = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= 4'd2;
         colon_ff  <= 1'b0;
      end else begin
         bright_ff <= bright_in;
         colon_ff  <= colon_in;
      end
   end

   // The front classifies each command and turns a number into four segment bytes.
   tldw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_number       (req_number),
      .brightness_level (bright_ff),
      .colon_on         (colon_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   // The queue lets the front take the next command while the back is still sending.
   tldw_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .wdata      (q_wdata),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // The back frames the bytes and emits start, data, ack and stop symbols.
   tldw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol_kind (rsp_symbol_kind),
      .rsp_bit_value   (rsp_bit_value),
      .rsp_last_symbol (rsp_last_symbol)
   );

endmodule
